// File: src/env_sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// env_sc_pkg
// shared types, codes and helpers of the sensor compensation unit
// ----------------------------------------------------------------------------
package env_sc_pkg;

  localparam logic [1:0] CMD_TEMP   = 2'd0;
  localparam logic [1:0] CMD_PRESS  = 2'd1;
  localparam logic [1:0] CMD_HUM    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_TEMP       = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_HUM  = 3'd3;
  localparam logic [2:0] REG_HUM_HIGH   = 3'd4;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
    ST_P9, ST_P10, ST_P11, ST_PDIV, ST_P13, ST_P14, ST_P15, ST_P16,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8, ST_H9,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // signed divide by 2**k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                 input int unsigned k);
    logic [31:0] bias;
    bias = x[31] ? ~(32'hFFFF_FFFF << k) : 32'd0;
    return (x + $signed(bias)) >>> k;
  endfunction

endpackage
`default_nettype wire

// File: src/env_sc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// env_sc_div
// unsigned 32 by 32 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module env_sc_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire env_sc_pkg::div_req_t req,
  output env_sc_pkg::div_rsp_t      rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [33:0] diff;

  assign diff = {1'b0, rem, quo[31]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[33]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule
`default_nettype wire

// File: src/env_sensor_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// env_sensor_compensation_unit
// integer compensation of temperature, pressure and humidity readings
// ----------------------------------------------------------------------------
// One reading is taken at a time and runs through a small sequencer around a
// single shared 32x32 multiplier. A pressure reading also waits on the
// 32-step bit-serial divider, which it skips when the divisor is zero; an
// unused kind code goes straight to the result. The unit returns to idle after
// each reading before the next is taken. Temperature readings update the stored
// fine temperature used by later pressure and humidity readings. The finished
// result sits in an output register, so a new reading is taken while it waits.
module env_sensor_compensation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // raw_value[19:0], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // compensated[17:0], zero pad
  output logic [1:0]       m_tuser,   // kind[1:0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  env_sc_pkg::state_t state, state_next;
  env_sc_pkg::div_req_t div_req;
  env_sc_pkg::div_rsp_t div_rsp;

  logic [47:0] temp_coeffs;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [47:0] press_hum;
  logic [31:0] hum_high;

  logic signed [31:0] fine;
  logic signed [31:0] r_a, r_b, r_c, r_d, r_e;
  logic [31:0]        r_p;
  logic [19:0]        raw;
  logic [1:0]         kind;
  logic signed [17:0] r_res;

  logic [31:0] mul_a, mul_b, prod;
  logic        out_free;

  logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  logic signed [31:0] t_res, p_sum, h_v5;
  logic [31:0]        p_fin;

  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  assign p1 = {16'd0, press_low[15:0]};
  assign p2 = {{16{press_low[31]}}, press_low[31:16]};
  assign p3 = {{16{press_low[47]}}, press_low[47:32]};
  assign p4 = {{16{press_low[63]}}, press_low[63:48]};
  assign p5 = {{16{press_high[15]}}, press_high[15:0]};
  assign p6 = {{16{press_high[31]}}, press_high[31:16]};
  assign p7 = {{16{press_high[47]}}, press_high[47:32]};
  assign p8 = {{16{press_high[63]}}, press_high[63:48]};
  assign p9 = {{16{press_hum[15]}}, press_hum[15:0]};
  assign h1 = {24'd0, press_hum[23:16]};
  assign h2 = {{16{press_hum[39]}}, press_hum[39:24]};
  assign h3 = {24'd0, press_hum[47:40]};
  assign h4 = {{20{hum_high[11]}}, hum_high[11:0]};
  assign h5 = {{20{hum_high[23]}}, hum_high[23:12]};
  assign h6 = {{24{hum_high[31]}}, hum_high[31:24]};

  assign s_tready = (state == env_sc_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign prod     = mul_a * mul_b;

  env_sc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      env_sc_pkg::ST_T0: begin
        mul_a = {15'd0, raw[19:3]} - {t1[30:0], 1'b0};
        mul_b = t2;
      end
      env_sc_pkg::ST_T1: begin
        mul_a = {16'd0, raw[19:4]} - t1;
        mul_b = {16'd0, raw[19:4]} - t1;
      end
      env_sc_pkg::ST_T2: begin
        mul_a = r_b;
        mul_b = t3;
      end
      env_sc_pkg::ST_T4: begin
        mul_a = fine;
        mul_b = 32'd5;
      end
      env_sc_pkg::ST_P1: begin
        mul_a = env_sc_pkg::sdiv_p2(r_a, 2);
        mul_b = env_sc_pkg::sdiv_p2(r_a, 2);
      end
      env_sc_pkg::ST_P2: begin
        mul_a = env_sc_pkg::sdiv_p2(r_b, 11);
        mul_b = p6;
      end
      env_sc_pkg::ST_P3: begin
        mul_a = r_a;
        mul_b = p5;
      end
      env_sc_pkg::ST_P5: begin
        mul_a = env_sc_pkg::sdiv_p2(r_b, 13);
        mul_b = p3;
      end
      env_sc_pkg::ST_P6: begin
        mul_a = r_a;
        mul_b = p2;
      end
      env_sc_pkg::ST_P8: begin
        mul_a = r_a + 32'sd32768;
        mul_b = p1;
      end
      env_sc_pkg::ST_P10: begin
        mul_a = r_p;
        mul_b = 32'd3125;
      end
      env_sc_pkg::ST_P13: begin
        mul_a = {3'd0, r_p[31:3]};
        mul_b = {3'd0, r_p[31:3]};
      end
      env_sc_pkg::ST_P14: begin
        mul_a = r_b;
        mul_b = p9;
      end
      env_sc_pkg::ST_P15: begin
        mul_a = {2'd0, r_p[31:2]};
        mul_b = p8;
      end
      env_sc_pkg::ST_H1: begin
        mul_a = r_a;
        mul_b = h5;
      end
      env_sc_pkg::ST_H3: begin
        mul_a = r_a;
        mul_b = h6;
      end
      env_sc_pkg::ST_H4: begin
        mul_a = r_a;
        mul_b = h3;
      end
      env_sc_pkg::ST_H5: begin
        mul_a = r_c;
        mul_b = r_d + 32'sd32768;
      end
      env_sc_pkg::ST_H6: begin
        mul_a = r_e;
        mul_b = h2;
      end
      env_sc_pkg::ST_H7: begin
        mul_a = r_b;
        mul_b = r_c;
      end
      env_sc_pkg::ST_H8: begin
        mul_a = env_sc_pkg::sdiv_p2(r_d, 15);
        mul_b = env_sc_pkg::sdiv_p2(r_d, 15);
      end
      env_sc_pkg::ST_H9: begin
        mul_a = r_e;
        mul_b = h1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // final-step values before clamping
  assign t_res = env_sc_pkg::sdiv_p2($signed(prod) + 32'sd128, 8);
  assign p_sum = env_sc_pkg::sdiv_p2(r_d + r_e + p7, 4);
  assign p_fin = r_p + p_sum;
  assign h_v5  = r_d - env_sc_pkg::sdiv_p2($signed(prod), 4);

  always_comb begin
    div_req.start    = (state == env_sc_pkg::ST_P11);
    div_req.dividend = r_p[31] ? r_p : {r_p[30:0], 1'b0};
    div_req.divisor  = r_a;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      env_sc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            env_sc_pkg::CMD_TEMP:  state_next = env_sc_pkg::ST_T0;
            env_sc_pkg::CMD_PRESS: state_next = env_sc_pkg::ST_P0;
            env_sc_pkg::CMD_HUM:   state_next = env_sc_pkg::ST_H0;
            default:               state_next = env_sc_pkg::ST_DONE;
          endcase
        end
      end
      env_sc_pkg::ST_T0:   state_next = env_sc_pkg::ST_T1;
      env_sc_pkg::ST_T1:   state_next = env_sc_pkg::ST_T2;
      env_sc_pkg::ST_T2:   state_next = env_sc_pkg::ST_T3;
      env_sc_pkg::ST_T3:   state_next = env_sc_pkg::ST_T4;
      env_sc_pkg::ST_T4:   state_next = env_sc_pkg::ST_DONE;
      env_sc_pkg::ST_P0:   state_next = env_sc_pkg::ST_P1;
      env_sc_pkg::ST_P1:   state_next = env_sc_pkg::ST_P2;
      env_sc_pkg::ST_P2:   state_next = env_sc_pkg::ST_P3;
      env_sc_pkg::ST_P3:   state_next = env_sc_pkg::ST_P4;
      env_sc_pkg::ST_P4:   state_next = env_sc_pkg::ST_P5;
      env_sc_pkg::ST_P5:   state_next = env_sc_pkg::ST_P6;
      env_sc_pkg::ST_P6:   state_next = env_sc_pkg::ST_P7;
      env_sc_pkg::ST_P7:   state_next = env_sc_pkg::ST_P8;
      env_sc_pkg::ST_P8:   state_next = env_sc_pkg::ST_P9;
      env_sc_pkg::ST_P9: begin
        state_next = (r_a == 32'sd0) ? env_sc_pkg::ST_DONE : env_sc_pkg::ST_P10;
      end
      env_sc_pkg::ST_P10:  state_next = env_sc_pkg::ST_P11;
      env_sc_pkg::ST_P11:  state_next = env_sc_pkg::ST_PDIV;
      env_sc_pkg::ST_PDIV: begin
        if (div_rsp.done) begin
          state_next = env_sc_pkg::ST_P13;
        end
      end
      env_sc_pkg::ST_P13:  state_next = env_sc_pkg::ST_P14;
      env_sc_pkg::ST_P14:  state_next = env_sc_pkg::ST_P15;
      env_sc_pkg::ST_P15:  state_next = env_sc_pkg::ST_P16;
      env_sc_pkg::ST_P16:  state_next = env_sc_pkg::ST_DONE;
      env_sc_pkg::ST_H0:   state_next = env_sc_pkg::ST_H1;
      env_sc_pkg::ST_H1:   state_next = env_sc_pkg::ST_H2;
      env_sc_pkg::ST_H2:   state_next = env_sc_pkg::ST_H3;
      env_sc_pkg::ST_H3:   state_next = env_sc_pkg::ST_H4;
      env_sc_pkg::ST_H4:   state_next = env_sc_pkg::ST_H5;
      env_sc_pkg::ST_H5:   state_next = env_sc_pkg::ST_H6;
      env_sc_pkg::ST_H6:   state_next = env_sc_pkg::ST_H7;
      env_sc_pkg::ST_H7:   state_next = env_sc_pkg::ST_H8;
      env_sc_pkg::ST_H8:   state_next = env_sc_pkg::ST_H9;
      env_sc_pkg::ST_H9:   state_next = env_sc_pkg::ST_DONE;
      env_sc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = env_sc_pkg::ST_IDLE;
        end
      end
      default: state_next = env_sc_pkg::ST_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= env_sc_pkg::ST_IDLE;
      m_tvalid    <= 1'b0;
      fine        <= '0;
      temp_coeffs <= '0;
      press_low   <= '0;
      press_high  <= '0;
      press_hum   <= '0;
      hum_high    <= '0;
    end else begin
      state <= state_next;
      if (state == env_sc_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == env_sc_pkg::ST_T3) begin
        fine <= r_a + r_b;
      end
      if (cfg_we) begin
        case (cfg_index)
          env_sc_pkg::REG_TEMP:       temp_coeffs <= cfg_data[47:0];
          env_sc_pkg::REG_PRESS_LOW:  press_low   <= cfg_data;
          env_sc_pkg::REG_PRESS_HIGH: press_high  <= cfg_data;
          env_sc_pkg::REG_PRESS_HUM:  press_hum   <= cfg_data[47:0];
          env_sc_pkg::REG_HUM_HIGH:   hum_high    <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == env_sc_pkg::ST_DONE && out_free) begin
      m_tdata <= {6'd0, r_res};
      m_tuser <= kind;
    end
    case (state)
      env_sc_pkg::ST_IDLE: begin
        raw   <= s_tdata[19:0];
        kind  <= s_tuser;
        r_res <= '0;
      end
      env_sc_pkg::ST_T0: r_a <= env_sc_pkg::sdiv_p2($signed(prod), 11);
      env_sc_pkg::ST_T1: r_b <= env_sc_pkg::sdiv_p2($signed(prod), 12);
      env_sc_pkg::ST_T2: r_b <= env_sc_pkg::sdiv_p2($signed(prod), 14);
      env_sc_pkg::ST_T4: begin
        if (t_res < -32'sd4000) begin
          r_res <= -18'sd4000;
        end else if (t_res > 32'sd8500) begin
          r_res <= 18'sd8500;
        end else begin
          r_res <= t_res[17:0];
        end
      end
      env_sc_pkg::ST_P0: r_a <= env_sc_pkg::sdiv_p2(fine, 1) - 32'sd64000;
      env_sc_pkg::ST_P1: r_b <= prod;
      env_sc_pkg::ST_P2: r_c <= prod;
      env_sc_pkg::ST_P3: r_c <= r_c + $signed({prod[30:0], 1'b0});
      env_sc_pkg::ST_P4: r_c <= env_sc_pkg::sdiv_p2(r_c, 2) + $signed({p4[15:0], 16'd0});
      env_sc_pkg::ST_P5: r_d <= env_sc_pkg::sdiv_p2($signed(prod), 3);
      env_sc_pkg::ST_P6: r_e <= env_sc_pkg::sdiv_p2($signed(prod), 1);
      env_sc_pkg::ST_P7: r_a <= env_sc_pkg::sdiv_p2(r_d + r_e, 18);
      env_sc_pkg::ST_P8: r_a <= env_sc_pkg::sdiv_p2($signed(prod), 15);
      env_sc_pkg::ST_P9: begin
        r_res <= 18'sd30000;
        r_p   <= (32'd1048576 - {12'd0, raw}) - env_sc_pkg::sdiv_p2(r_c, 12);
      end
      env_sc_pkg::ST_P10: r_p <= prod;
      env_sc_pkg::ST_PDIV: begin
        if (div_rsp.done) begin
          r_p <= r_p[31] ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;
        end
      end
      env_sc_pkg::ST_P13: r_b <= {13'd0, prod[31:13]};
      env_sc_pkg::ST_P14: r_d <= env_sc_pkg::sdiv_p2($signed(prod), 12);
      env_sc_pkg::ST_P15: r_e <= env_sc_pkg::sdiv_p2($signed(prod), 13);
      env_sc_pkg::ST_P16: begin
        if (p_fin < 32'd30000) begin
          r_res <= 18'sd30000;
        end else if (p_fin > 32'd110000) begin
          r_res <= 18'sd110000;
        end else begin
          r_res <= p_fin[17:0];
        end
      end
      env_sc_pkg::ST_H0: r_a <= fine - 32'sd76800;
      env_sc_pkg::ST_H1: r_e <= prod;
      env_sc_pkg::ST_H2: begin
        r_b <= env_sc_pkg::sdiv_p2($signed({2'd0, raw[15:0], 14'd0})
                                   - $signed({h4[11:0], 20'd0}) - r_e + 32'sd16384, 15);
      end
      env_sc_pkg::ST_H3: r_c <= env_sc_pkg::sdiv_p2($signed(prod), 10);
      env_sc_pkg::ST_H4: r_d <= env_sc_pkg::sdiv_p2($signed(prod), 11);
      env_sc_pkg::ST_H5: r_e <= env_sc_pkg::sdiv_p2($signed(prod), 10) + 32'sd2097152;
      env_sc_pkg::ST_H6: r_c <= env_sc_pkg::sdiv_p2($signed(prod) + 32'sd8192, 14);
      env_sc_pkg::ST_H7: r_d <= prod;
      env_sc_pkg::ST_H8: r_e <= env_sc_pkg::sdiv_p2($signed(prod), 7);
      env_sc_pkg::ST_H9: begin
        if (h_v5 < 32'sd0) begin
          r_res <= '0;
        end else if (h_v5 > 32'sd419430400) begin
          r_res <= 18'sd102400;
        end else begin
          r_res <= $signed({1'b0, h_v5[28:12]});
        end
      end
      default: ;
    endcase
  end

  // checks
  property p_busy_after_take;
    @(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready;
  endproperty
  a_busy_after_take: assert property (p_busy_after_take)
    else $error("input taken while a reading is in progress");

  property p_press_range;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == env_sc_pkg::CMD_PRESS) |->
      ($signed(m_tdata[17:0]) >= 18'sd30000 && $signed(m_tdata[17:0]) <= 18'sd110000);
  endproperty
  a_press_range: assert property (p_press_range)
    else $error("pressure result out of range");

  property p_temp_range;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == env_sc_pkg::CMD_TEMP) |->
      ($signed(m_tdata[17:0]) >= -18'sd4000 && $signed(m_tdata[17:0]) <= 18'sd8500);
  endproperty
  a_temp_range: assert property (p_temp_range)
    else $error("temperature result out of range");

  property p_div_leaves;
    @(posedge clk) disable iff (rst)
      (state == env_sc_pkg::ST_PDIV && div_rsp.done) |=> state == env_sc_pkg::ST_P13;
  endproperty
  a_div_leaves: assert property (p_div_leaves)
    else $error("divider result not consumed");

endmodule
`default_nettype wire
